@@ src/min_max_normalizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Min-max normalizer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_NORMALIZER_CORE_DEFINES_SVH
`define MIN_MAX_NORMALIZER_CORE_DEFINES_SVH

// same-cycle implication
`define MMN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MMN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mmn_pkg.sv @@
// ----------------------------------------------------------------------------
// Min-max normalizer package
// Item types, function codes, state encodings and log2 format constants.
// ----------------------------------------------------------------------------
package mmn_pkg;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_GATHER = 2'd1;
	localparam logic [1:0] FUNC_NORM   = 2'd2;

	localparam int NORM_W      = 17;
	localparam int LOG_INT_W   = 6;
	localparam int MANT_W      = 32;
	localparam int LOG_W       = LOG_INT_W + MANT_W;
	localparam int DIGIT_W     = 4;
	localparam int DIGITS      = MANT_W / DIGIT_W;
	localparam int DCNT_W      = $clog2(DIGITS);
	localparam int SQCNT_W     = $clog2(MANT_W);

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] sample_value;
		logic               sample_is_nan;
	} in_item_t;

	typedef struct packed {
		logic [NORM_W-1:0] normalized;
		logic              degenerate;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LMIN,
		S_LMAX,
		S_LX,
		S_DIV,
		S_OUT
	} mmn_state_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_MUL
	} mmn_lstate_t;

endpackage

@@ src/mmn_log2.sv @@
// ----------------------------------------------------------------------------
// Min-max normalizer log2 unit
// Leading-one search one bit per cycle, then 32 squarings of a Q1.31
// mantissa, each done by a 4-bit-digit serial multiply.
// ----------------------------------------------------------------------------
module mmn_log2 #(
	parameter int VW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [VW-1:0]              value,
	output logic                       done,
	output logic [mmn_pkg::LOG_W-1:0]  result
);

	localparam int NW = VW + mmn_pkg::MANT_W;
	localparam int CW = $clog2(VW);
	localparam int MW = mmn_pkg::MANT_W;
	localparam int DW = mmn_pkg::DIGIT_W;
	localparam int PW = MW + DW;
	localparam logic [mmn_pkg::LOG_INT_W-1:0] EMAX = mmn_pkg::LOG_INT_W'(VW - 1);
	localparam logic [mmn_pkg::DCNT_W-1:0] DLAST = mmn_pkg::DCNT_W'(mmn_pkg::DIGITS - 1);
	localparam logic [mmn_pkg::SQCNT_W-1:0] SQLAST = mmn_pkg::SQCNT_W'(MW - 1);

	mmn_pkg::mmn_lstate_t state_q, state_d;

	logic [NW-1:0]                     nrm_q;
	logic [CW-1:0]                     k_q;
	logic [MW-1:0]                     m_q;
	logic [MW-1:0]                     mdig_q;
	logic [2*MW-1:0]                   acc_q;
	logic [mmn_pkg::DCNT_W-1:0]        dcnt_q;
	logic [mmn_pkg::SQCNT_W-1:0]       sq_q;
	logic [MW-1:0]                     fr_q;
	logic [mmn_pkg::LOG_INT_W-1:0]     e_q;
	logic                              done_q;
	logic [mmn_pkg::LOG_W-1:0]         result_q;

	logic [PW-1:0]   prod;
	logic [2*MW-1:0] sum;
	logic [MW:0]     p;
	logic [MW-1:0]   m_nxt;
	logic [MW-1:0]   fr_nxt;

	assign prod   = PW'(m_q) * PW'(mdig_q[MW-1 -: DW]);
	assign sum    = {acc_q[2*MW-DW-1:0], {DW{1'b0}}} + (2*MW)'(prod);
	assign p      = sum[2*MW-1:MW-1];
	assign m_nxt  = p[MW] ? p[MW:1] : p[MW-1:0];
	assign fr_nxt = {fr_q[MW-2:0], p[MW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmn_pkg::L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmn_pkg::L_IDLE: begin
				if (start) state_d = mmn_pkg::L_NORM;
			end
			mmn_pkg::L_NORM: begin
				if (nrm_q[NW-1]) state_d = mmn_pkg::L_MUL;
			end
			mmn_pkg::L_MUL: begin
				if (dcnt_q == DLAST && sq_q == SQLAST) state_d = mmn_pkg::L_IDLE;
			end
			default: state_d = mmn_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == mmn_pkg::L_MUL) && (dcnt_q == DLAST) && (sq_q == SQLAST);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mmn_pkg::L_IDLE: begin
				if (start) begin
					nrm_q <= {value, {MW{1'b0}}};
					k_q   <= '0;
				end
			end
			mmn_pkg::L_NORM: begin
				if (nrm_q[NW-1]) begin
					m_q    <= nrm_q[NW-1 -: MW];
					mdig_q <= nrm_q[NW-1 -: MW];
					acc_q  <= '0;
					dcnt_q <= '0;
					sq_q   <= '0;
					fr_q   <= '0;
					e_q    <= EMAX - mmn_pkg::LOG_INT_W'(k_q);
				end else begin
					nrm_q <= {nrm_q[NW-2:0], 1'b0};
					k_q   <= k_q + 1'b1;
				end
			end
			mmn_pkg::L_MUL: begin
				if (dcnt_q == DLAST) begin
					m_q    <= m_nxt;
					mdig_q <= m_nxt;
					acc_q  <= '0;
					dcnt_q <= '0;
					fr_q   <= fr_nxt;
					sq_q   <= sq_q + 1'b1;
					if (sq_q == SQLAST) result_q <= {e_q, fr_nxt};
				end else begin
					acc_q  <= sum;
					mdig_q <= {mdig_q[MW-DW-1:0], {DW{1'b0}}};
					dcnt_q <= dcnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ src/mmn_div.sv @@
// ----------------------------------------------------------------------------
// Min-max normalizer divider
// Restoring division, one quotient bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module mmn_div #(
	parameter int DW = 38,
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [FB:0]   quo
);

	localparam int RW = FB + 1;
	localparam int CW = $clog2(FB + 1);
	localparam logic [CW-1:0] CLAST = CW'(FB);
	localparam logic [RW-1:0] ONE = {1'b1, {FB{1'b0}}};

	logic          run_q;
	logic          done_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] den_q;
	logic [RW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] quo_q;

	logic [DW:0]   rs;
	logic          ge;
	logic [DW:0]   rdiff;
	logic [RW-1:0] q_nxt;
	logic [RW:0]   rnd;

	assign rs    = {r_q, 1'b0};
	assign ge    = rs >= {1'b0, den_q};
	assign rdiff = rs - {1'b0, den_q};
	assign q_nxt = {q_q[RW-2:0], ge};
	assign rnd   = {1'b0, q_nxt} + (RW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (run_q) begin
				if (cnt_q == CLAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				if (den == '0 || num >= den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			r_q   <= ge ? rdiff[DW-1:0] : rs[DW-1:0];
			q_q   <= q_nxt;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CLAST) quo_q <= rnd[RW:1];
		end else if (start) begin
			r_q   <= num;
			den_q <= den;
			q_q   <= '0;
			cnt_q <= '0;
			if (den == '0) quo_q <= '0;
			else if (num >= den) quo_q <= ONE;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ src/min_max_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// Min-max normalizer core
// Two-pass min/max statistics and per-sample linear or log2 normalization.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_item) takes one item with func clear,
//   gather or normalize. Clear and gather finish in the accepting cycle and
//   the next item can be taken in the cycle after; they give no output item.
//   A normalize item gives one out item (normalized Q1.16, degenerate).
//   cfg_we/cfg_wdata write log_scale; write only while the core is idle.
//   Path of a normalize item, from accept to out_valid:
//     degenerate or clamped: straight to the out register
//     linear: through the bit-serial divider
//     log: three log2 runs (min, max, sample), each a leading-one search
//       plus 32 squarings, then the bit-serial divider
//   One normalize item is in flight at a time; in_stall is high meanwhile.
//   A finished item waits in the out register while out_stall is high, and
//   the next item is accepted meanwhile. Reset clears statistics and mode.
// ----------------------------------------------------------------------------
module min_max_normalizer_core #(
	parameter int SAMPLE_BITS   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mmn_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output mmn_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int SB = SAMPLE_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int RW = FB + 1;
	localparam int LW = mmn_pkg::LOG_W;
	localparam int DW = (SB > LW) ? SB : LW;
	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic [RW-1:0] ONE = {1'b1, {FB{1'b0}}};

	mmn_pkg::mmn_state_t state_q, state_d;

	logic signed [SB-1:0] min_q, max_q, x_q;
	logic                 seen_q;
	logic                 log_q;
	logic [LW-1:0]        lmin_q, lmax_q;
	logic [RW-1:0]        res_n_q;
	logic                 res_d_q;
	logic                 out_valid_q;
	mmn_pkg::out_item_t   out_item_q;

	logic [SB+31:0]       xw;
	logic signed [SB-1:0] x;
	logic                 accept, is_norm, deg, lo, hi, fast, move;
	logic [SB:0]          dx, dspan;
	logic                 log_start, log_done;
	logic [SB-1:0]        log_val;
	logic [LW-1:0]        log_res;
	logic                 div_start, div_done;
	logic [DW-1:0]        div_num, div_den;
	logic [FB:0]          div_quo;
	logic [RW+15:0]       res_ext;

	assign xw      = {{SB{in_item.sample_value[31]}}, in_item.sample_value};
	assign x       = xw[SB-1:0];
	assign accept  = in_valid && !in_stall;
	assign is_norm = in_item.func == mmn_pkg::FUNC_NORM;
	assign deg     = !seen_q || (max_q <= min_q) || (log_q && (min_q[SB-1] || min_q == '0));
	assign lo      = in_item.sample_is_nan || (x <= min_q);
	assign hi      = x >= max_q;
	assign fast    = deg || lo || hi;
	assign move    = !out_valid_q || !out_stall;
	assign dx      = {x[SB-1], x} - {min_q[SB-1], min_q};
	assign dspan   = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};

	assign log_start = (state_q == mmn_pkg::S_IDLE && accept && is_norm && !fast && log_q) ||
	                   (state_q == mmn_pkg::S_LMIN && log_done) ||
	                   (state_q == mmn_pkg::S_LMAX && log_done);
	assign log_val   = (state_q == mmn_pkg::S_IDLE) ? min_q :
	                   (state_q == mmn_pkg::S_LMIN) ? max_q : x_q;

	assign div_start = (state_q == mmn_pkg::S_IDLE && accept && is_norm && !fast && !log_q) ||
	                   (state_q == mmn_pkg::S_LX && log_done);
	assign div_num   = (state_q == mmn_pkg::S_LX) ? DW'(log_res - lmin_q) : DW'(dx[SB-1:0]);
	assign div_den   = (state_q == mmn_pkg::S_LX) ? DW'(lmax_q - lmin_q) : DW'(dspan[SB-1:0]);

	mmn_log2 #(.VW(SB)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.value  (log_val),
		.done   (log_done),
		.result (log_res)
	);

	mmn_div #(.DW(DW), .FB(FB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmn_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmn_pkg::S_IDLE: begin
				if (accept && is_norm) begin
					if (fast) state_d = mmn_pkg::S_OUT;
					else if (log_q) state_d = mmn_pkg::S_LMIN;
					else state_d = mmn_pkg::S_DIV;
				end
			end
			mmn_pkg::S_LMIN: if (log_done) state_d = mmn_pkg::S_LMAX;
			mmn_pkg::S_LMAX: if (log_done) state_d = mmn_pkg::S_LX;
			mmn_pkg::S_LX:   if (log_done) state_d = mmn_pkg::S_DIV;
			mmn_pkg::S_DIV:  if (div_done) state_d = mmn_pkg::S_OUT;
			mmn_pkg::S_OUT:  if (move) state_d = mmn_pkg::S_IDLE;
			default: state_d = mmn_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q       <= 1'b0;
			min_q       <= SMAX;
			max_q       <= SMIN;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) log_q <= cfg_wdata;
			if (accept && in_item.func == mmn_pkg::FUNC_CLEAR) begin
				min_q  <= SMAX;
				max_q  <= SMIN;
				seen_q <= 1'b0;
			end else if (accept && in_item.func == mmn_pkg::FUNC_GATHER &&
			             !in_item.sample_is_nan) begin
				if (!log_q || (!x[SB-1] && x != '0)) begin
					if (x < min_q) min_q <= x;
					seen_q <= 1'b1;
				end
				if (x > max_q) max_q <= x;
			end
			if (state_q == mmn_pkg::S_OUT && move) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign res_ext = {16'b0, res_n_q};

	always_ff @(posedge clk) begin
		if (accept) x_q <= x;
		if (state_q == mmn_pkg::S_IDLE && accept && is_norm) begin
			res_d_q <= deg;
			if (deg || lo) res_n_q <= '0;
			else res_n_q <= ONE;
		end
		if (state_q == mmn_pkg::S_LMIN && log_done) lmin_q <= log_res;
		if (state_q == mmn_pkg::S_LMAX && log_done) lmax_q <= log_res;
		if (state_q == mmn_pkg::S_DIV && div_done) begin
			res_n_q <= div_quo;
			res_d_q <= 1'b0;
		end
		if (state_q == mmn_pkg::S_OUT && move) begin
			out_item_q.normalized <= res_ext[mmn_pkg::NORM_W-1:0];
			out_item_q.degenerate <= res_d_q;
		end
	end

	assign in_stall  = state_q != mmn_pkg::S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ src/mmn_checker.sv @@
// ----------------------------------------------------------------------------
// Min-max normalizer port checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_max_normalizer_core_defines.svh"

module mmn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input mmn_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input mmn_pkg::out_item_t out_item
);

	`MMN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled out item changed")
	`MMN_ASSERT_NOW(a_deg_zero, out_valid && out_item.degenerate, out_item.normalized == '0, "degenerate item with nonzero value")
	`MMN_ASSERT_NEXT(a_norm_busy, in_valid && !in_stall && in_item.func == mmn_pkg::FUNC_NORM, in_stall, "normalize item not held busy")
	`MMN_ASSERT_NEXT(a_stat_free, in_valid && !in_stall && in_item.func != mmn_pkg::FUNC_NORM, !in_stall, "statistics item left core busy")

endmodule

bind min_max_normalizer_core mmn_checker u_mmn_checker (.*);
